// ===== hdl/apcsp_pkg.sv =====
// shared constants, types and tables for the arc pair c-space surface sampler
`timescale 1ns / 1ps
package apcsp_pkg;

	localparam int STEP_W = 3;
	localparam int COORD_W = 32;
	localparam int RAD_W = 30;
	localparam int ANGIN_W = 15;
	localparam int END_W = 17;
	localparam int ANG_W = 19;
	localparam int THETA_W = 17;
	localparam int NUM_W = 23;
	localparam int RECIP_W = 25;
	localparam int RECIP_SHIFT = 24;
	localparam int CORD_W = 34;
	localparam int PROD_W = 66;
	localparam int SUM_W = 68;
	localparam int FRAC_SHIFT = 30;
	localparam int ATAN_LEN = 24;

	localparam int DEF_MAX_STEPS = 7;
	localparam int DEF_CORDIC_ITERATIONS = 16;

	localparam logic signed [ANG_W-1:0] ANG_PI = 19'sd12868;
	localparam logic signed [ANG_W-1:0] ANG_PI2 = 19'sd25736;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 19'sd6434;
	localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [STEP_W-1:0] STEPS_RESET = 3'd7;

	typedef enum logic {
		CFG_PHI_STEPS = 1'b0,
		CFG_ROTATION_STEPS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic [STEP_W-1:0] j;
		logic [STEP_W-1:0] i;
		logic last;
		logic signed [THETA_W-1:0] theta;
		logic neg_p;
		logic neg_t;
	} side_t;

	function automatic logic signed [CORD_W-1:0] atan_q(input int k);
		logic signed [CORD_W-1:0] r;
		case (k)
			0: r = 34'sd210828714;
			1: r = 34'sd124459457;
			2: r = 34'sd65760959;
			3: r = 34'sd33381290;
			4: r = 34'sd16755422;
			5: r = 34'sd8385879;
			6: r = 34'sd4193963;
			7: r = 34'sd2097109;
			8: r = 34'sd1048571;
			9: r = 34'sd524287;
			10: r = 34'sd262144;
			11: r = 34'sd131072;
			12: r = 34'sd65536;
			13: r = 34'sd32768;
			14: r = 34'sd16384;
			15: r = 34'sd8192;
			16: r = 34'sd4096;
			17: r = 34'sd2048;
			18: r = 34'sd1024;
			19: r = 34'sd512;
			20: r = 34'sd256;
			21: r = 34'sd128;
			22: r = 34'sd64;
			23: r = 34'sd32;
			default: r = '0;
		endcase
		return r;
	endfunction

	// ceil(2^24 / d), exact floor division for the numerator range
	function automatic logic [RECIP_W-1:0] recip_q(input logic [STEP_W-1:0] d);
		logic [RECIP_W-1:0] r;
		case (d)
			3'd1: r = 25'd16777216;
			3'd2: r = 25'd8388608;
			3'd3: r = 25'd5592406;
			3'd4: r = 25'd4194304;
			3'd5: r = 25'd3355444;
			3'd6: r = 25'd2796203;
			3'd7: r = 25'd2396746;
			default: r = 25'd16777216;
		endcase
		return r;
	endfunction

	// end angle raised by a full turn until it is not below begin
	function automatic logic signed [END_W-1:0] raise_end(
		input logic signed [ANGIN_W-1:0] b,
		input logic signed [ANGIN_W-1:0] e
	);
		logic signed [END_W-1:0] bw;
		logic signed [END_W-1:0] ew;
		bw = END_W'(b);
		ew = END_W'(e);
		if (ew < bw) begin
			ew = ew + END_W'(ANG_PI2);
		end
		if (ew < bw) begin
			ew = ew + END_W'(ANG_PI2);
		end
		return ew;
	endfunction

endpackage

// ===== hdl/arc_pair_cspace_surface_points_core.sv =====
// top level: arc pair c-space surface point generator with pipelined cordic datapath
//
// channel | dir | handshake            | payload
// arc     | in  | arc_valid/arc_stall  | robot_* and obstacle_* fields
// point   | out | point_valid/point_stall | point_x, point_y, rotation_angle, indexes, last
// cfg     | in  | cfg_we               | cfg_index, cfg_data
//
// one arc pair is taken at a time; it issues one grid point per cycle into the datapath
// unless point_stall holds it, (J+1)*(I+1) points in all from the point issue counter
// arc_stall stays high from a transaction until its last point has been taken
// point_stall freezes the whole datapath while point_valid is high; reset clears the
// valid bits and the grid counters and sets the step registers to STEPS_RESET
`timescale 1ns / 1ps
module arc_pair_cspace_surface_points_core #(
	parameter int MAX_STEPS = apcsp_pkg::DEF_MAX_STEPS,
	parameter int CORDIC_ITERATIONS = apcsp_pkg::DEF_CORDIC_ITERATIONS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [apcsp_pkg::STEP_W-1:0] cfg_data,
	input  logic arc_valid,
	output logic arc_stall,
	input  logic signed [apcsp_pkg::COORD_W-1:0] robot_center_x,
	input  logic signed [apcsp_pkg::COORD_W-1:0] robot_center_y,
	input  logic [apcsp_pkg::RAD_W-1:0] robot_radius,
	input  logic signed [apcsp_pkg::ANGIN_W-1:0] robot_angle_first,
	input  logic signed [apcsp_pkg::ANGIN_W-1:0] robot_angle_second,
	input  logic robot_ccw,
	input  logic signed [apcsp_pkg::COORD_W-1:0] obstacle_center_x,
	input  logic signed [apcsp_pkg::COORD_W-1:0] obstacle_center_y,
	input  logic [apcsp_pkg::RAD_W-1:0] obstacle_radius,
	input  logic signed [apcsp_pkg::ANGIN_W-1:0] obstacle_angle_first,
	input  logic signed [apcsp_pkg::ANGIN_W-1:0] obstacle_angle_second,
	input  logic obstacle_ccw,
	output logic point_valid,
	input  logic point_stall,
	output logic signed [apcsp_pkg::COORD_W-1:0] point_x,
	output logic signed [apcsp_pkg::COORD_W-1:0] point_y,
	output logic signed [apcsp_pkg::THETA_W-1:0] rotation_angle,
	output logic [apcsp_pkg::STEP_W-1:0] phi_index,
	output logic [apcsp_pkg::STEP_W-1:0] rotation_index,
	output logic last
);

	localparam int N = CORDIC_ITERATIONS;
	localparam int SW = apcsp_pkg::STEP_W;
	localparam int AW = apcsp_pkg::ANG_W;
	localparam int EW = apcsp_pkg::END_W;
	localparam int NW = apcsp_pkg::NUM_W;
	localparam int CW = apcsp_pkg::CORD_W;
	localparam int PW = apcsp_pkg::PROD_W;
	localparam int UW = apcsp_pkg::SUM_W;
	localparam int RW = apcsp_pkg::RECIP_W;
	localparam int QW = NW + RW;
	localparam logic [SW-1:0] MAX_STEPS_V = SW'(MAX_STEPS);

	logic [SW-1:0] phi_steps_q;
	logic [SW-1:0] rotation_steps_q;

	logic busy_q;
	logic gen_q;
	logic [SW-1:0] j_q;
	logic [SW-1:0] i_q;
	logic [SW-1:0] jn_q;
	logic [SW-1:0] in_q;

	logic signed [apcsp_pkg::COORD_W-1:0] rcx_q, rcy_q, ocx_q, ocy_q;
	logic [apcsp_pkg::RAD_W:0] rad_q;
	logic signed [EW-1:0] b0_q, e0_q, b1_q, e1_q;

	logic adv;
	logic arc_take;
	logic issue;
	logic issue_last;

	function automatic logic [SW-1:0] clamp_steps(input logic [SW-1:0] v);
		logic [SW-1:0] s;
		s = v;
		if (s == '0) begin
			s = SW'(1);
		end
		if (s > MAX_STEPS_V) begin
			s = MAX_STEPS_V;
		end
		return s;
	endfunction

	function automatic logic signed [AW-1:0] reduce_ang(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] r;
		r = a;
		if (r > apcsp_pkg::ANG_PI) begin
			r = r - apcsp_pkg::ANG_PI2;
		end else if (r < -apcsp_pkg::ANG_PI) begin
			r = r + apcsp_pkg::ANG_PI2;
		end
		if (r > apcsp_pkg::ANG_PI) begin
			r = r - apcsp_pkg::ANG_PI2;
		end else if (r < -apcsp_pkg::ANG_PI) begin
			r = r + apcsp_pkg::ANG_PI2;
		end
		return r;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phi_steps_q <= apcsp_pkg::STEPS_RESET;
			rotation_steps_q <= apcsp_pkg::STEPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				apcsp_pkg::CFG_PHI_STEPS: phi_steps_q <= cfg_data;
				apcsp_pkg::CFG_ROTATION_STEPS: rotation_steps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = !(point_valid && point_stall);
	assign arc_stall = busy_q;
	assign arc_take = arc_valid && !busy_q;
	assign issue = gen_q && adv;
	assign issue_last = (j_q == jn_q) && (i_q == in_q);

	// point sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			gen_q <= 1'b0;
			j_q <= '0;
			i_q <= '0;
		end else begin
			if (arc_take) begin
				busy_q <= 1'b1;
				gen_q <= 1'b1;
				j_q <= '0;
				i_q <= '0;
			end else begin
				if (issue) begin
					if (i_q == in_q) begin
						i_q <= '0;
						if (j_q == jn_q) begin
							gen_q <= 1'b0;
						end else begin
							j_q <= j_q + SW'(1);
						end
					end else begin
						i_q <= i_q + SW'(1);
					end
				end
				if (point_valid && !point_stall && last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (arc_take) begin
			rcx_q <= robot_center_x;
			rcy_q <= robot_center_y;
			ocx_q <= obstacle_center_x;
			ocy_q <= obstacle_center_y;
			rad_q <= {1'b0, robot_radius} + {1'b0, obstacle_radius};
			jn_q <= clamp_steps(phi_steps_q);
			in_q <= clamp_steps(rotation_steps_q);
			if (robot_ccw) begin
				b0_q <= EW'(robot_angle_first);
				e0_q <= apcsp_pkg::raise_end(robot_angle_first, robot_angle_second);
			end else begin
				b0_q <= EW'(robot_angle_second);
				e0_q <= apcsp_pkg::raise_end(robot_angle_second, robot_angle_first);
			end
			if (obstacle_ccw) begin
				b1_q <= EW'(obstacle_angle_first);
				e1_q <= apcsp_pkg::raise_end(obstacle_angle_first, obstacle_angle_second);
			end else begin
				b1_q <= EW'(obstacle_angle_second);
				e1_q <= apcsp_pkg::raise_end(obstacle_angle_second, obstacle_angle_first);
			end
		end
	end

	// stage 1: interpolation numerators
	logic signed [NW-1:0] nphi_c, ntmp_c;
	logic signed [NW-1:0] nphi_s1, ntmp_s1;
	apcsp_pkg::side_t sd_c, sd_s1, sd_s2, sd_s3, sd_s4;

	always_comb begin
		nphi_c = NW'(b1_q) * NW'($signed({2'b00, jn_q - j_q}))
			+ NW'(e1_q) * NW'($signed({2'b00, j_q}));
		ntmp_c = -(NW'(e0_q) * NW'($signed({2'b00, in_q - i_q}))
			+ NW'(b0_q) * NW'($signed({2'b00, i_q})));
		sd_c = '0;
		sd_c.valid = gen_q;
		sd_c.j = j_q;
		sd_c.i = i_q;
		sd_c.last = issue_last;
	end

	// stage 2: magnitude times reciprocal
	logic [QW-1:0] pphi_s2, ptmp_s2;
	logic sphi_s2, stmp_s2;
	logic [NW-1:0] aphi_c, atmp_c;

	always_comb begin
		aphi_c = nphi_s1[NW-1] ? NW'(-nphi_s1) : NW'(nphi_s1);
		atmp_c = ntmp_s1[NW-1] ? NW'(-ntmp_s1) : NW'(ntmp_s1);
	end

	// stage 3: quotients, truncated toward zero
	logic signed [AW-1:0] phi_s3, tmp_s3;
	logic [AW-1:0] qphi_c, qtmp_c;

	always_comb begin
		qphi_c = AW'(pphi_s2 >> apcsp_pkg::RECIP_SHIFT);
		qtmp_c = AW'(ptmp_s2 >> apcsp_pkg::RECIP_SHIFT);
	end

	// stage 4: theta
	logic signed [AW-1:0] phi_s4, theta_s4;

	// stage 5 onward: cordic
	logic signed [CW-1:0] px_s [0:N];
	logic signed [CW-1:0] py_s [0:N];
	logic signed [CW-1:0] pz_s [0:N];
	logic signed [CW-1:0] tx_s [0:N];
	logic signed [CW-1:0] ty_s [0:N];
	logic signed [CW-1:0] tz_s [0:N];
	apcsp_pkg::side_t cs_s [0:N];

	logic signed [AW-1:0] rphi_c, rth_c, fphi_c, fth_c;
	logic nphi_neg_c, nth_neg_c;

	always_comb begin
		rphi_c = reduce_ang(phi_s4);
		rth_c = reduce_ang(theta_s4);
		fphi_c = rphi_c;
		fth_c = rth_c;
		nphi_neg_c = 1'b0;
		nth_neg_c = 1'b0;
		if (rphi_c > apcsp_pkg::ANG_HALF_PI) begin
			fphi_c = rphi_c - apcsp_pkg::ANG_PI;
			nphi_neg_c = 1'b1;
		end else if (rphi_c < -apcsp_pkg::ANG_HALF_PI) begin
			fphi_c = rphi_c + apcsp_pkg::ANG_PI;
			nphi_neg_c = 1'b1;
		end
		if (rth_c > apcsp_pkg::ANG_HALF_PI) begin
			fth_c = rth_c - apcsp_pkg::ANG_PI;
			nth_neg_c = 1'b1;
		end else if (rth_c < -apcsp_pkg::ANG_HALF_PI) begin
			fth_c = rth_c + apcsp_pkg::ANG_PI;
			nth_neg_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_s1 <= '0;
			sd_s2 <= '0;
			sd_s3 <= '0;
			sd_s4 <= '0;
			cs_s[0] <= '0;
		end else if (adv) begin
			nphi_s1 <= nphi_c;
			ntmp_s1 <= ntmp_c;
			sd_s1.valid <= sd_c.valid;
			sd_s1.j <= sd_c.j;
			sd_s1.i <= sd_c.i;
			sd_s1.last <= sd_c.last;
			sd_s1.theta <= sd_c.theta;
			sd_s1.neg_p <= sd_c.neg_p;
			sd_s1.neg_t <= sd_c.neg_t;

			pphi_s2 <= QW'(aphi_c) * QW'(apcsp_pkg::recip_q(jn_q));
			ptmp_s2 <= QW'(atmp_c) * QW'(apcsp_pkg::recip_q(in_q));
			sphi_s2 <= nphi_s1[NW-1];
			stmp_s2 <= ntmp_s1[NW-1];
			sd_s2.valid <= sd_s1.valid;
			sd_s2.j <= sd_s1.j;
			sd_s2.i <= sd_s1.i;
			sd_s2.last <= sd_s1.last;
			sd_s2.theta <= sd_s1.theta;
			sd_s2.neg_p <= sd_s1.neg_p;
			sd_s2.neg_t <= sd_s1.neg_t;

			phi_s3 <= sphi_s2 ? -$signed(qphi_c) : $signed(qphi_c);
			tmp_s3 <= stmp_s2 ? -$signed(qtmp_c) : $signed(qtmp_c);
			sd_s3.valid <= sd_s2.valid;
			sd_s3.j <= sd_s2.j;
			sd_s3.i <= sd_s2.i;
			sd_s3.last <= sd_s2.last;
			sd_s3.theta <= sd_s2.theta;
			sd_s3.neg_p <= sd_s2.neg_p;
			sd_s3.neg_t <= sd_s2.neg_t;

			phi_s4 <= phi_s3;
			theta_s4 <= tmp_s3 + phi_s3;
			sd_s4.valid <= sd_s3.valid;
			sd_s4.j <= sd_s3.j;
			sd_s4.i <= sd_s3.i;
			sd_s4.last <= sd_s3.last;
			sd_s4.theta <= apcsp_pkg::THETA_W'(tmp_s3 + phi_s3);
			sd_s4.neg_p <= sd_s3.neg_p;
			sd_s4.neg_t <= sd_s3.neg_t;

			px_s[0] <= apcsp_pkg::CORDIC_GAIN;
			py_s[0] <= '0;
			pz_s[0] <= CW'(fphi_c) <<< 16;
			tx_s[0] <= apcsp_pkg::CORDIC_GAIN;
			ty_s[0] <= '0;
			tz_s[0] <= CW'(fth_c) <<< 16;
			cs_s[0].valid <= sd_s4.valid;
			cs_s[0].j <= sd_s4.j;
			cs_s[0].i <= sd_s4.i;
			cs_s[0].last <= sd_s4.last;
			cs_s[0].theta <= sd_s4.theta;
			cs_s[0].neg_p <= nphi_neg_c;
			cs_s[0].neg_t <= nth_neg_c;
		end
	end

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_cordic
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cs_s[k+1] <= '0;
				end else if (adv) begin
					cs_s[k+1] <= cs_s[k];
					if (pz_s[k] >= 0) begin
						px_s[k+1] <= px_s[k] - (py_s[k] >>> k);
						py_s[k+1] <= py_s[k] + (px_s[k] >>> k);
						pz_s[k+1] <= pz_s[k] - apcsp_pkg::atan_q(k);
					end else begin
						px_s[k+1] <= px_s[k] + (py_s[k] >>> k);
						py_s[k+1] <= py_s[k] - (px_s[k] >>> k);
						pz_s[k+1] <= pz_s[k] + apcsp_pkg::atan_q(k);
					end
					if (tz_s[k] >= 0) begin
						tx_s[k+1] <= tx_s[k] - (ty_s[k] >>> k);
						ty_s[k+1] <= ty_s[k] + (tx_s[k] >>> k);
						tz_s[k+1] <= tz_s[k] - apcsp_pkg::atan_q(k);
					end else begin
						tx_s[k+1] <= tx_s[k] + (ty_s[k] >>> k);
						ty_s[k+1] <= ty_s[k] - (tx_s[k] >>> k);
						tz_s[k+1] <= tz_s[k] + apcsp_pkg::atan_q(k);
					end
				end
			end
		end
	endgenerate

	// products, partial sums, rounding and saturation
	logic signed [CW-1:0] cp_c, sp_c, ct_c, st_c;
	logic signed [CW-1:0] rad_s;
	logic signed [PW-1:0] m_xct_sm, m_yst_sm, m_rcp_sm, m_xst_sm, m_yct_sm, m_rsp_sm;
	logic signed [UW-1:0] ax_sa, bx_sa, ay_sa, by_sa;
	logic signed [UW-1:0] tx_sb, ty_sb;
	apcsp_pkg::side_t sd_sm, sd_sa, sd_sb;
	logic signed [apcsp_pkg::COORD_W-1:0] sat_x_c, sat_y_c;

	assign rad_s = CW'($signed({1'b0, rad_q}));

	always_comb begin
		cp_c = cs_s[N].neg_p ? -px_s[N] : px_s[N];
		sp_c = cs_s[N].neg_p ? -py_s[N] : py_s[N];
		ct_c = cs_s[N].neg_t ? -tx_s[N] : tx_s[N];
		st_c = cs_s[N].neg_t ? -ty_s[N] : ty_s[N];
	end

	function automatic logic signed [apcsp_pkg::COORD_W-1:0] sat_round(
		input logic signed [UW-1:0] v
	);
		logic signed [apcsp_pkg::COORD_W-1:0] r;
		logic [UW-apcsp_pkg::FRAC_SHIFT-apcsp_pkg::COORD_W:0] top;
		top = v[UW-1:apcsp_pkg::FRAC_SHIFT+apcsp_pkg::COORD_W-1];
		if (top == '0 || top == '1) begin
			r = v[apcsp_pkg::FRAC_SHIFT+apcsp_pkg::COORD_W-1:apcsp_pkg::FRAC_SHIFT];
		end else if (v[UW-1]) begin
			r = {1'b1, {(apcsp_pkg::COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(apcsp_pkg::COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	always_comb begin
		sat_x_c = sat_round(tx_sb);
		sat_y_c = sat_round(ty_sb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_sm <= '0;
			sd_sa <= '0;
			sd_sb <= '0;
			point_valid <= 1'b0;
		end else if (adv) begin
			m_xct_sm <= PW'(rcx_q) * PW'(ct_c);
			m_yst_sm <= PW'(rcy_q) * PW'(st_c);
			m_rcp_sm <= PW'(rad_s) * PW'(cp_c);
			m_xst_sm <= PW'(rcx_q) * PW'(st_c);
			m_yct_sm <= PW'(rcy_q) * PW'(ct_c);
			m_rsp_sm <= PW'(rad_s) * PW'(sp_c);
			sd_sm <= cs_s[N];

			ax_sa <= {{(UW-apcsp_pkg::COORD_W-apcsp_pkg::FRAC_SHIFT){ocx_q[apcsp_pkg::COORD_W-1]}},
				ocx_q, {apcsp_pkg::FRAC_SHIFT{1'b0}}} + UW'(m_xct_sm);
			bx_sa <= UW'(m_rcp_sm) - UW'(m_yst_sm);
			ay_sa <= {{(UW-apcsp_pkg::COORD_W-apcsp_pkg::FRAC_SHIFT){ocy_q[apcsp_pkg::COORD_W-1]}},
				ocy_q, {apcsp_pkg::FRAC_SHIFT{1'b0}}} + UW'(m_xst_sm);
			by_sa <= UW'(m_rsp_sm) + UW'(m_yct_sm);
			sd_sa <= sd_sm;

			tx_sb <= ax_sa + bx_sa + (UW'(1) <<< (apcsp_pkg::FRAC_SHIFT - 1));
			ty_sb <= ay_sa + by_sa + (UW'(1) <<< (apcsp_pkg::FRAC_SHIFT - 1));
			sd_sb <= sd_sa;

			point_valid <= sd_sb.valid;
			point_x <= sat_x_c;
			point_y <= sat_y_c;
			rotation_angle <= sd_sb.theta;
			phi_index <= sd_sb.j;
			rotation_index <= sd_sb.i;
			last <= sd_sb.last;
		end
	end

	// results only while an arc pair is in flight
	a_point_busy: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> busy_q)
		else $error("point without arc pair in flight");

	// issue only while in flight
	a_gen_busy: assert property (@(posedge clk) disable iff (!arst_n)
		gen_q |-> busy_q)
		else $error("issuing without arc pair");

	// the last point drains the datapath
	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall && last |=> !point_valid && !gen_q)
		else $error("datapath not empty after last point");

	// issuing the final grid point stops the sequencer
	a_issue_stop: assert property (@(posedge clk) disable iff (!arst_n)
		issue && issue_last && !arc_take |=> !gen_q)
		else $error("sequencer ran past last grid point");

endmodule
